// ===== src/dptt_pkg.sv =====
// ----------------------------------------------------------------------------
// dptt_pkg
// Types, codes and defaults shared by the task table sequencer and its parts.
// ----------------------------------------------------------------------------
package dptt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 4;
    localparam int OUT_CNT_W = 5;

    localparam logic [OP_W-1:0] OP_SET      = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 4'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 4'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 4'd2;
    localparam logic [STAT_W-1:0] ST_NULL     = 4'd3;
    localparam logic [STAT_W-1:0] ST_DELETED  = 4'd4;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 4'd5;
    localparam logic [STAT_W-1:0] ST_TICKED   = 4'd6;
    localparam logic [STAT_W-1:0] ST_RUN      = 4'd7;
    localparam logic [STAT_W-1:0] ST_NONE     = 4'd8;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic              ready;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   match;
        logic   zero_period;
        t_entry tick_e;
        t_entry disp_e;
    } t_alu_res;

endpackage

// ===== src/delayed_periodic_task_table_unit.sv =====
// ----------------------------------------------------------------------------
// delayed_periodic_task_table_unit
// Task table with delayed and periodic ids: set, delete, tick and dispatch.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   operation, task_id,
//                                                 start_delay, run_period
//   out      source     o_out_valid / i_out_ready result_id, status, last,
//                                                 entries_used
//
// Set, delete and tick stream the table through one RAM read port at one
// entry per cycle; a delete before the tail then moves the tail entry into
// the freed slot. Dispatch reads each entry and then checks it; a one-shot
// removal moves the tail entry into the freed slot the same way. Reset
// clears the state, fill count and valid flags; entries are written before
// they are read. The sequencer holds while the result register is full;
// the next item is taken while the last result waits.
// ----------------------------------------------------------------------------
module delayed_periodic_task_table_unit #(
    parameter int TABLE_DEPTH = dptt_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dptt_pkg::OP_W-1:0]         i_operation,
    input  logic [dptt_pkg::ID_W-1:0]         i_task_id,
    input  logic [dptt_pkg::TIME_W-1:0]       i_start_delay,
    input  logic [dptt_pkg::TIME_W-1:0]       i_run_period,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dptt_pkg::ID_W-1:0]         o_result_id,
    output logic [dptt_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last,
    output logic [dptt_pkg::OUT_CNT_W-1:0]    o_entries_used
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    dptt_pkg::t_entry           ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    dptt_pkg::t_entry           ram_rdata;
    logic [dptt_pkg::ID_W-1:0]  key;
    dptt_pkg::t_alu_res         alu_res;

    dptt_ram #(
        .WIDTH (dptt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dptt_alu u_alu (
        .i_entry (ram_rdata),
        .i_key   (key),
        .o_res   (alu_res)
    );

    dptt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .i_start_delay  (i_start_delay),
        .i_run_period   (i_run_period),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_id    (o_result_id),
        .o_status       (o_status),
        .o_last         (o_last),
        .o_entries_used (o_entries_used),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_key          (key),
        .i_alu          (alu_res)
    );

endmodule

// ===== src/dptt_ram.sv =====
// ----------------------------------------------------------------------------
// dptt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dptt_alu.sv =====
// ----------------------------------------------------------------------------
// dptt_alu
// Shared entry unit: id compare, tick update and dispatch update of one entry.
// ----------------------------------------------------------------------------
module dptt_alu (
    input  dptt_pkg::t_entry             i_entry,
    input  logic [dptt_pkg::ID_W-1:0]    i_key,
    output dptt_pkg::t_alu_res           o_res
);

    logic zero_delay;

    assign zero_delay = (i_entry.delay == '0);

    always_comb begin
        o_res.match       = (i_entry.id == i_key);
        o_res.zero_period = (i_entry.period == '0);

        o_res.tick_e = i_entry;
        if (zero_delay) begin
            o_res.tick_e.ready = 1'b1;
        end else begin
            o_res.tick_e.delay = i_entry.delay - 1'b1;
        end

        o_res.disp_e       = i_entry;
        o_res.disp_e.ready = 1'b0;
        if (zero_delay) begin
            o_res.disp_e.delay = i_entry.period - 1'b1;
        end
    end

endmodule

// ===== src/dptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dptt_ctrl
// Sequencer: walks the table one entry at a time and drives the result register.
// ----------------------------------------------------------------------------
module dptt_ctrl #(
    parameter int DEPTH = dptt_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dptt_pkg::OP_W-1:0]         i_operation,
    input  logic [dptt_pkg::ID_W-1:0]         i_task_id,
    input  logic [dptt_pkg::TIME_W-1:0]       i_start_delay,
    input  logic [dptt_pkg::TIME_W-1:0]       i_run_period,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dptt_pkg::ID_W-1:0]         o_result_id,
    output logic [dptt_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last,
    output logic [dptt_pkg::OUT_CNT_W-1:0]    o_entries_used,
    output logic                              o_ram_we,
    output logic [AW-1:0]                     o_ram_waddr,
    output dptt_pkg::t_entry                  o_ram_wdata,
    output logic                              o_ram_re,
    output logic [AW-1:0]                     o_ram_raddr,
    input  dptt_pkg::t_entry                  i_ram_rdata,
    output logic [dptt_pkg::ID_W-1:0]         o_key,
    input  dptt_pkg::t_alu_res                i_alu
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PAD_W = dptt_pkg::OUT_CNT_W + CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MVRD = 3'd2;
    localparam logic [2:0] S_MVWR = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DCHK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                       r_state, n_state;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [CNT_W-1:0]                 r_idx, n_idx;
    logic                             r_pv, n_pv;
    logic [AW-1:0]                    r_pidx, n_pidx;
    logic [AW-1:0]                    r_fidx, n_fidx;
    logic                             r_pend_v, n_pend_v;
    logic [dptt_pkg::ID_W-1:0]        r_pend_id, n_pend_id;
    logic [dptt_pkg::OP_W-1:0]        r_op, n_op;
    logic [dptt_pkg::ID_W-1:0]        r_id, n_id;
    logic [dptt_pkg::TIME_W-1:0]      r_dly, n_dly;
    logic [dptt_pkg::TIME_W-1:0]      r_per, n_per;
    logic [dptt_pkg::ID_W-1:0]        r_res_id, n_res_id;
    logic [dptt_pkg::STAT_W-1:0]      r_res_st, n_res_st;

    logic                             r_ov;
    logic [dptt_pkg::ID_W-1:0]        r_oid;
    logic [dptt_pkg::STAT_W-1:0]      r_ost;
    logic                             r_olast;
    logic [dptt_pkg::OUT_CNT_W-1:0]   r_ocnt;

    logic                             ld_out;
    logic [dptt_pkg::ID_W-1:0]        ld_id;
    logic [dptt_pkg::STAT_W-1:0]      ld_st;
    logic                             ld_last;

    logic                             out_free;
    logic                             idx_lt;
    logic [CNT_W-1:0]                 cnt_m1;
    logic [AW-1:0]                    idx_a;
    logic [AW-1:0]                    tail_a;
    logic [PAD_W-1:0]                 cnt_pad;
    dptt_pkg::t_entry                 set_e;

    assign out_free = !r_ov || i_out_ready;
    assign idx_lt   = (r_idx < r_cnt);
    assign cnt_m1   = r_cnt - 1'b1;
    assign idx_a    = r_idx[AW-1:0];
    assign tail_a   = cnt_m1[AW-1:0];
    assign cnt_pad  = {{dptt_pkg::OUT_CNT_W{1'b0}}, r_cnt};
    assign o_key    = r_id;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        set_e.id     = r_id;
        set_e.delay  = r_dly;
        set_e.period = r_per;
        set_e.ready  = 1'b0;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_fidx    = r_fidx;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        n_op      = r_op;
        n_id      = r_id;
        n_dly     = r_dly;
        n_per     = r_per;
        n_res_id  = r_res_id;
        n_res_st  = r_res_st;
        o_ram_we    = 1'b0;
        o_ram_waddr = idx_a;
        o_ram_wdata = set_e;
        o_ram_re    = 1'b0;
        o_ram_raddr = idx_a;
        ld_out  = 1'b0;
        ld_id   = r_res_id;
        ld_st   = r_res_st;
        ld_last = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_operation;
                    n_id     = i_task_id;
                    n_dly    = i_start_delay;
                    n_per    = i_run_period;
                    n_idx    = '0;
                    n_pv     = 1'b0;
                    n_pend_v = 1'b0;
                    if (i_operation == dptt_pkg::OP_SET && i_task_id == '0) begin
                        n_res_id = '0;
                        n_res_st = dptt_pkg::ST_NULL;
                        n_state  = S_DONE;
                    end else if (i_operation == dptt_pkg::OP_DISPATCH) begin
                        n_state = S_DRD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_ram_re    = idx_lt;
                o_ram_raddr = idx_a;
                if (idx_lt) begin
                    n_idx  = r_idx + 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = idx_a;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    case (r_op)
                        dptt_pkg::OP_TICK: begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_pidx;
                            o_ram_wdata = i_alu.tick_e;
                        end
                        dptt_pkg::OP_SET: begin
                            if (i_alu.match) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_pidx;
                                o_ram_wdata = set_e;
                                n_res_id    = r_id;
                                n_res_st    = dptt_pkg::ST_UPDATED;
                                n_state     = S_DONE;
                            end
                        end
                        dptt_pkg::OP_DELETE: begin
                            if (i_alu.match) begin
                                n_res_id = r_id;
                                n_res_st = dptt_pkg::ST_DELETED;
                                if (r_pidx == tail_a) begin
                                    n_cnt   = cnt_m1;
                                    n_state = S_DONE;
                                end else begin
                                    n_fidx  = r_pidx;
                                    n_state = S_MVRD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (!idx_lt) begin
                    n_state = S_DONE;
                    case (r_op)
                        dptt_pkg::OP_TICK: begin
                            n_res_id = '0;
                            n_res_st = dptt_pkg::ST_TICKED;
                        end
                        dptt_pkg::OP_SET: begin
                            n_res_id = r_id;
                            if (r_cnt < CNT_W'(DEPTH)) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_cnt[AW-1:0];
                                o_ram_wdata = set_e;
                                n_cnt       = r_cnt + 1'b1;
                                n_res_st    = dptt_pkg::ST_INSERTED;
                            end else begin
                                n_res_st = dptt_pkg::ST_FULL;
                            end
                        end
                        default: begin
                            n_res_id = r_id;
                            n_res_st = dptt_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_MVRD: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = tail_a;
                n_state     = S_MVWR;
            end
            S_MVWR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_fidx;
                o_ram_wdata = i_ram_rdata;
                n_cnt       = cnt_m1;
                if (r_op == dptt_pkg::OP_DISPATCH) begin
                    n_state = S_DRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DRD: begin
                if (idx_lt) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = idx_a;
                    n_state     = S_DCHK;
                end else begin
                    if (r_pend_v) begin
                        n_res_id = r_pend_id;
                        n_res_st = dptt_pkg::ST_RUN;
                    end else begin
                        n_res_id = '0;
                        n_res_st = dptt_pkg::ST_NONE;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_DCHK: begin
                if (!i_ram_rdata.ready) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DRD;
                end else if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        ld_out  = 1'b1;
                        ld_id   = r_pend_id;
                        ld_st   = dptt_pkg::ST_RUN;
                        ld_last = 1'b0;
                    end
                    n_pend_v  = 1'b1;
                    n_pend_id = i_ram_rdata.id;
                    if (i_alu.zero_period) begin
                        if (r_idx == cnt_m1) begin
                            n_cnt   = cnt_m1;
                            n_state = S_DRD;
                        end else begin
                            n_fidx  = idx_a;
                            n_state = S_MVRD;
                        end
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = idx_a;
                        o_ram_wdata = i_alu.disp_e;
                        n_idx       = r_idx + 1'b1;
                        n_state     = S_DRD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_fidx    <= n_fidx;
        r_pend_id <= n_pend_id;
        r_op      <= n_op;
        r_id      <= n_id;
        r_dly     <= n_dly;
        r_per     <= n_per;
        r_res_id  <= n_res_id;
        r_res_st  <= n_res_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_oid   <= ld_id;
            r_ost   <= ld_st;
            r_olast <= ld_last;
            r_ocnt  <= cnt_pad[dptt_pkg::OUT_CNT_W-1:0];
        end
    end

    assign o_out_valid    = r_ov;
    assign o_result_id    = r_oid;
    assign o_status       = r_ost;
    assign o_last         = r_olast;
    assign o_entries_used = r_ocnt;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_v)
        else $error("pending dispatch result left over in idle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> ({{CNT_W{1'b0}}, o_ram_waddr} <= {{AW{1'b0}}, r_cnt}))
        else $error("table write beyond fill count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_cnt == $past(r_cnt) || r_cnt == CNT_W'($past(r_cnt) + 1'b1)
            || r_cnt == CNT_W'($past(r_cnt) - 1'b1)))
        else $error("fill count moved by more than one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cnt <= CNT_W'(DEPTH)))
        else $error("fill count above table depth");

endmodule

// ===== sim/tb_delayed_periodic_task_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_delayed_periodic_task_table_unit
// Self-checking bench for the delayed periodic task table. A queue-fed driver
// sends set, delete, tick and dispatch items. A shadow copy of the table
// predicts every result. A monitor checks the results in order, field by
// field, while both handshakes idle in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module tb_delayed_periodic_task_table_unit;
    import dptt_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int TAIL_WAIT  = 100;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] per;
    } t_table_cmd;

    typedef struct {
        logic [ID_W-1:0]      id;
        logic [STAT_W-1:0]    status;
        logic                 last;
        logic [OUT_CNT_W-1:0] used;
    } t_table_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [ID_W-1:0]       i_task_id = '0;
    logic [TIME_W-1:0]     i_start_delay = '0;
    logic [TIME_W-1:0]     i_run_period = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [ID_W-1:0]       o_result_id;
    logic [STAT_W-1:0]     o_status;
    logic                  o_last;
    logic [OUT_CNT_W-1:0]  o_entries_used;

    // shadow table
    logic [ID_W-1:0]   sh_id     [DEPTH];
    logic [TIME_W-1:0] sh_delay  [DEPTH];
    logic [TIME_W-1:0] sh_period [DEPTH];
    logic              sh_ready  [DEPTH];
    int                sh_count = 0;

    t_table_cmd cmd_backlog[$];
    t_table_res predicted_results[$];

    int cmds_queued = 0;
    int cmds_taken = 0;
    int results_checked = 0;
    int errors = 0;
    int runs_predicted = 0;
    int full_predicted = 0;
    int peak_fill = 0;
    int cycle_cnt = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int in_gap = 0;
    int out_gap = 0;

    delayed_periodic_task_table_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .i_start_delay  (i_start_delay),
        .i_run_period   (i_run_period),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_id    (o_result_id),
        .o_status       (o_status),
        .o_last         (o_last),
        .o_entries_used (o_entries_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_table_res make_res(logic [ID_W-1:0] id, logic [STAT_W-1:0] st,
                                            logic last);
        t_table_res r;
        r.id     = id;
        r.status = st;
        r.last   = last;
        r.used   = sh_count[OUT_CNT_W-1:0];
        return r;
    endfunction

    task automatic drop_entry(input int slot);
        int tail;
        tail = sh_count - 1;
        if (slot != tail) begin
            sh_id[slot]     = sh_id[tail];
            sh_delay[slot]  = sh_delay[tail];
            sh_period[slot] = sh_period[tail];
            sh_ready[slot]  = sh_ready[tail];
        end
        sh_count = tail;
    endtask

    task automatic apply_table_op(input t_table_cmd c);
        int slot;
        int i;
        int n;
        logic [ID_W-1:0] rid;
        t_table_res held;
        slot = -1;
        for (i = 0; i < sh_count; i++) begin
            if (slot < 0 && sh_id[i] == c.id)
                slot = i;
        end
        case (c.op)
            OP_SET: begin
                if (c.id == '0) begin
                    predicted_results.push_back(make_res('0, ST_NULL, 1'b1));
                end else if (slot >= 0) begin
                    sh_delay[slot]  = c.dly;
                    sh_period[slot] = c.per;
                    sh_ready[slot]  = 1'b0;
                    predicted_results.push_back(make_res(c.id, ST_UPDATED, 1'b1));
                end else if (sh_count < DEPTH) begin
                    sh_id[sh_count]     = c.id;
                    sh_delay[sh_count]  = c.dly;
                    sh_period[sh_count] = c.per;
                    sh_ready[sh_count]  = 1'b0;
                    sh_count++;
                    if (sh_count > peak_fill)
                        peak_fill = sh_count;
                    predicted_results.push_back(make_res(c.id, ST_INSERTED, 1'b1));
                end else begin
                    full_predicted++;
                    predicted_results.push_back(make_res(c.id, ST_FULL, 1'b1));
                end
            end
            OP_DELETE: begin
                if (slot >= 0) begin
                    drop_entry(slot);
                    predicted_results.push_back(make_res(c.id, ST_DELETED, 1'b1));
                end else begin
                    predicted_results.push_back(make_res(c.id, ST_NOTFOUND, 1'b1));
                end
            end
            OP_TICK: begin
                for (i = 0; i < sh_count; i++) begin
                    if (sh_delay[i] == '0)
                        sh_ready[i] = 1'b1;
                    else
                        sh_delay[i] = sh_delay[i] - 1'b1;
                end
                predicted_results.push_back(make_res('0, ST_TICKED, 1'b1));
            end
            default: begin
                // one-shot removal re-examines the entry moved into the slot
                i = 0;
                n = 0;
                while (i < sh_count && n < DEPTH) begin
                    if (sh_ready[i]) begin
                        rid = sh_id[i];
                        if (sh_period[i] == '0) begin
                            drop_entry(i);
                        end else begin
                            sh_ready[i] = 1'b0;
                            if (sh_delay[i] == '0)
                                sh_delay[i] = sh_period[i] - 1'b1;
                            i++;
                        end
                        if (n > 0)
                            predicted_results.push_back(held);
                        held = make_res(rid, ST_RUN, 1'b0);
                        n++;
                        runs_predicted++;
                    end else begin
                        i++;
                    end
                end
                if (n == 0) begin
                    predicted_results.push_back(make_res('0, ST_NONE, 1'b1));
                end else begin
                    held.last = 1'b1;
                    predicted_results.push_back(held);
                end
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_table_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                c.op  = i_operation;
                c.id  = i_task_id;
                c.dly = i_start_delay;
                c.per = i_run_period;
                apply_table_op(c);
                cmds_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0 &&
                             $urandom_range(99, 0) < in_idle_pct) begin
                    in_gap = $urandom_range(18, 0);
                    i_in_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    c = cmd_backlog.pop_front();
                    i_operation   <= c.op;
                    i_task_id     <= c.id;
                    i_start_delay <= c.dly;
                    i_run_period  <= c.per;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    // monitor and result-side stalls
    always @(posedge i_clk) begin
        t_table_res e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: id %0d status %0d", o_result_id, o_status);
                    errors++;
                end else begin
                    e = predicted_results.pop_front();
                    check_field("result_id", int'(e.id), int'(o_result_id));
                    check_field("status", int'(e.status), int'(o_status));
                    check_field("last", int'(e.last), int'(o_last));
                    check_field("entries_used", int'(e.used), int'(o_entries_used));
                end
                results_checked++;
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(99, 0) < out_idle_pct) begin
                out_gap = $urandom_range(18, 0);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] per);
        t_table_cmd c;
        c.op  = op;
        c.id  = id;
        c.dly = dly;
        c.per = per;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_random(input int count);
        int k;
        int pick;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] per;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 80)
                id = ID_W'($urandom_range(20, 1));
            else if (pick < 86)
                id = '0;
            else
                id = ID_W'($urandom);
            dly = ($urandom_range(7, 0) == 0) ? TIME_W'($urandom)
                                              : TIME_W'($urandom_range(3, 0));
            pick = $urandom_range(15, 0);
            if (pick < 5)
                per = '0;
            else if (pick == 15)
                per = TIME_W'($urandom);
            else
                per = TIME_W'($urandom_range(5, 1));
            pick = $urandom_range(99, 0);
            if (pick < 38)
                queue_cmd(OP_SET, id, dly, per);
            else if (pick < 50)
                queue_cmd(OP_DELETE, id, TIME_W'($urandom), TIME_W'($urandom));
            else if (pick < 77)
                queue_cmd(OP_TICK, ID_W'($urandom), TIME_W'($urandom),
                          TIME_W'($urandom));
            else
                queue_cmd(OP_DISPATCH, ID_W'($urandom), TIME_W'($urandom),
                          TIME_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (cmds_taken != cmds_queued || predicted_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct  = 15;
        out_idle_pct = 15;
        queue_cmd(OP_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_TICK, 8'hAA, 16'h5555, 16'hAAAA);
        queue_cmd(OP_DELETE, 8'h00, 16'hFFFF, 16'h0000);
        queue_cmd(OP_SET, 8'h00, 16'd5, 16'd5);
        queue_cmd(OP_SET, 8'hFF, 16'd0, 16'd0);
        queue_cmd(OP_SET, 8'h01, 16'd0, 16'd1);
        queue_cmd(OP_SET, 8'h02, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_SET, 8'h03, 16'd0, 16'd0);
        queue_cmd(OP_SET, 8'h01, 16'd0, 16'd1);
        queue_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000);
        queue_cmd(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        queue_cmd(OP_DELETE, 8'h02, 16'h0000, 16'h0000);
        for (k = 1; k < DEPTH; k++)
            queue_cmd(OP_SET, ID_W'(8'h40 + k), 16'd0, (k % 2) ? 16'd0 : 16'(k));
        queue_cmd(OP_SET, 8'h80, 16'd1, 16'd1);
        queue_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000);
        queue_cmd(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000);
        // sender holds until the table has answered everything
        wait_drained();

        in_idle_pct  = 25;
        out_idle_pct = 20;
        queue_random(35);
        wait_drained();

        in_idle_pct  = 5;
        out_idle_pct = 40;
        queue_random(20);
        wait_drained();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        repeat (20) @(negedge i_clk);
        queue_random(15);
        wait_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);

        $display("Ran %0d items through the table, checked %0d results.",
                 cmds_taken, results_checked);
        $display("Runs dispatched: %0d, full-table rejects: %0d, peak fill: %0d.",
                 runs_predicted, full_predicted, peak_fill);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dptt_pkg.sv
src/dptt_ram.sv
src/dptt_alu.sv
src/dptt_ctrl.sv
src/delayed_periodic_task_table_unit.sv
sim/tb_delayed_periodic_task_table_unit.sv
